/* design/lavm_pkg.sv */
// lavm_pkg: shared types, constants and saturation helpers for the look-at camera block
// no dependencies; imported by lavm_mul, lavm_norm and look_at_view_matrix
package lavm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int AX_W      = FRAC_BITS + 2;
	localparam int DIFF_W    = WORD_BITS + 1;
	localparam int PROD_W    = 2 * WORD_BITS;
	localparam int ACC_W     = PROD_W;

	localparam logic signed [ACC_W-1:0] ONE      = ACC_W'(1) <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] STEP_005 = ACC_W'(((1 << FRAC_BITS) * 5 + 50) / 100);
	localparam logic signed [ACC_W-1:0] WMAX     = (ACC_W'(1) <<< (WORD_BITS - 1)) - 1;
	localparam logic signed [ACC_W-1:0] WMIN     = -(ACC_W'(1) <<< (WORD_BITS - 1));

	typedef logic signed [AX_W-1:0]      axis_t;
	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [DIFF_W-1:0]    diff_t;
	typedef logic signed [ACC_W-1:0]     acc_t;

	typedef enum logic [1:0] {
		OP_LOOK    = 2'd0,
		OP_LOOK_AT = 2'd1,
		OP_MOVE    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// tag that travels with a product through the multiplier register
	typedef struct packed {
		logic       vld;
		logic       neg;
		logic       last;
		logic [1:0] grp;
	} mtag_t;

	function automatic axis_t clamp_axis(input acc_t x);
		acc_t r;
		r = (x > ONE) ? ONE : ((x < -ONE) ? -ONE : x);
		return r[AX_W-1:0];
	endfunction

	function automatic word_t sat_word(input acc_t x);
		acc_t r;
		r = (x > WMAX) ? WMAX : ((x < WMIN) ? WMIN : x);
		return r[WORD_BITS-1:0];
	endfunction

endpackage

/* design/lavm_mul.sv */
// lavm_mul: shared signed multiplier with a registered product and tag
// depends on lavm_pkg
module lavm_mul import lavm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  word_t                    a,
	input  word_t                    b,
	input  mtag_t                    tag,
	output logic signed [PROD_W-1:0] p_s1,
	output mtag_t                    tag_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

/* design/lavm_norm.sv */
// lavm_norm: iterative vector normalizer (shift search, sum of squares, square root, division)
// depends on lavm_pkg
module lavm_norm import lavm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  diff_t d0,
	input  diff_t d1,
	input  diff_t d2,
	output logic  done,
	output axis_t o0,
	output axis_t o1,
	output axis_t o2
);

	localparam int VW   = 31;
	localparam int SQW  = 2 * VW;
	localparam int RW   = 64;
	localparam int REMW = 32;
	localparam int QW   = AX_W - 1;
	localparam logic [DIFF_W-1:0] HI_LIM = DIFF_W'(1) << 30;
	localparam logic [DIFF_W-1:0] LO_LIM = DIFF_W'(1) << 29;

	typedef enum logic [5:0] {
		N_IDLE  = 6'b000001,
		N_SHIFT = 6'b000010,
		N_SQ    = 6'b000100,
		N_ROOT  = 6'b001000,
		N_DIV   = 6'b010000,
		N_DONE  = 6'b100000
	} nst_t;

	nst_t               st_q;
	diff_t              v_q [3];
	logic [DIFF_W-1:0]  m_q;
	logic [1:0]         cnt_q;
	logic [SQW-1:0]     sq_q;
	logic [RW-1:0]      sum_q, x_q, res_q, bit_q;
	logic [REMW-1:0]    rem_q;
	logic [QW-1:0]      nb_q, q_q;
	logic [4:0]         dcnt_q;
	logic               dsetup_q;
	axis_t              o_q [3];

	logic [DIFF_W-1:0]  m0, m1, m2, mmax;
	diff_t              vsel;
	logic [VW-1:0]      vmag;
	logic [REMW:0]      trial;
	logic [REMW-1:0]    len;
	logic               fits;
	logic [QW-1:0]      qnew;
	logic [RW-1:0]      rb;

	function automatic logic [DIFF_W-1:0] mag(input diff_t x);
		diff_t n;
		n = (x < 0) ? -x : x;
		return n;
	endfunction

	always_comb begin
		m0   = mag(d0);
		m1   = mag(d1);
		m2   = mag(d2);
		mmax = (m0 > m1) ? m0 : m1;
		if (m2 > mmax) begin
			mmax = m2;
		end
		unique case (cnt_q)
			2'd0:    vsel = v_q[0];
			2'd1:    vsel = v_q[1];
			default: vsel = v_q[2];
		endcase
		vmag  = VW'(mag(vsel));
		len   = res_q[REMW-1:0];
		trial = {rem_q, nb_q[QW-1]};
		fits  = trial >= {1'b0, len};
		qnew  = {q_q[QW-2:0], fits};
		rb    = res_q + bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= N_IDLE;
			cnt_q    <= '0;
			dcnt_q   <= '0;
			dsetup_q <= 1'b0;
		end else begin
			unique case (st_q)
				N_IDLE: begin
					if (start) begin
						st_q <= (mmax == '0) ? N_DONE : N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (m_q < HI_LIM && m_q >= LO_LIM) begin
						st_q  <= N_SQ;
						cnt_q <= '0;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						st_q <= N_ROOT;
					end
				end
				N_ROOT: begin
					if (bit_q[0]) begin
						st_q     <= N_DIV;
						cnt_q    <= '0;
						dsetup_q <= 1'b1;
					end
				end
				N_DIV: begin
					if (dsetup_q) begin
						dsetup_q <= 1'b0;
						dcnt_q   <= '0;
					end else begin
						dcnt_q <= dcnt_q + 5'd1;
						if (dcnt_q == 5'(QW - 1)) begin
							if (cnt_q == 2'd2) begin
								st_q <= N_DONE;
							end else begin
								cnt_q    <= cnt_q + 2'd1;
								dsetup_q <= 1'b1;
							end
						end
					end
				end
				default: begin
					st_q <= N_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			N_IDLE: begin
				if (start) begin
					v_q[0] <= d0;
					v_q[1] <= d1;
					v_q[2] <= d2;
					m_q    <= mmax;
					if (mmax == '0) begin
						o_q[0] <= '0;
						o_q[1] <= '0;
						o_q[2] <= '0;
					end
				end
			end
			N_SHIFT: begin
				if (m_q >= HI_LIM) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] >>> 1;
				end else if (m_q < LO_LIM) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] <<< 1;
				end
				sum_q <= '0;
			end
			N_SQ: begin
				if (cnt_q != 2'd3) begin
					sq_q <= SQW'($signed(vsel[VW-1:0]) * $signed(vsel[VW-1:0]));
				end
				if (cnt_q != 2'd0) begin
					sum_q <= sum_q + RW'(sq_q);
				end
				if (cnt_q == 2'd3) begin
					x_q   <= sum_q + RW'(sq_q);
					res_q <= '0;
					bit_q <= RW'(1) << (RW - 2);
				end
			end
			N_ROOT: begin
				if (x_q >= rb) begin
					x_q   <= x_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIV: begin
				if (dsetup_q) begin
					rem_q <= REMW'(vmag >> 1);
					nb_q  <= {vmag[0], {(QW-1){1'b0}}};
					q_q   <= '0;
				end else begin
					rem_q <= fits ? REMW'(trial - {1'b0, len}) : trial[REMW-1:0];
					q_q   <= qnew;
					nb_q  <= nb_q << 1;
					if (dcnt_q == 5'(QW - 1)) begin
						unique case (cnt_q)
							2'd0:    o_q[0] <= vsel[DIFF_W-1] ? -{1'b0, qnew} : {1'b0, qnew};
							2'd1:    o_q[1] <= vsel[DIFF_W-1] ? -{1'b0, qnew} : {1'b0, qnew};
							default: o_q[2] <= vsel[DIFF_W-1] ? -{1'b0, qnew} : {1'b0, qnew};
						endcase
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done = (st_q == N_DONE);
	assign o0   = o_q[0];
	assign o1   = o_q[1];
	assign o2   = o_q[2];

endmodule

/* design/look_at_view_matrix.sv */
// look_at_view_matrix: look-at camera that keeps eye, focus and basis and emits the view matrix
// depends on lavm_pkg, lavm_norm and lavm_mul
//
// One item is taken at a time. After a transfer on the input the block holds in_stall high
// while it works, shows the result with out_valid, and takes the next item once the result
// transfer has happened. A move or an unused op runs the nine multiplies of the translation
// through the shared multiplier. A look or look_at rebuilds the basis with two passes of the
// iterative normalizer, each with up to 29 shift steps, the sum of squares, 32 square root
// steps and one division per component, then 6 multiplies for the up axis, 3 more for the eye
// step of a look with orbit 0, and the translation. A zero view axis cuts both normalizer
// passes short, a view axis along the up vector only the second one. Eye, focus and
// translation are signed Q16.16, rotation entries signed Q2.16; sums saturate.
module look_at_view_matrix import lavm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic               orbit,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] r00,
	output logic signed [17:0] r01,
	output logic signed [17:0] r02,
	output logic signed [17:0] r10,
	output logic signed [17:0] r11,
	output logic signed [17:0] r12,
	output logic signed [17:0] r20,
	output logic signed [17:0] r21,
	output logic signed [17:0] r22,
	output logic signed [31:0] t_x,
	output logic signed [31:0] t_y,
	output logic signed [31:0] t_z
);

	// top sequencer
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ZGO   = 7'b0000010,
		S_ZWAIT = 7'b0000100,
		S_XGO   = 7'b0001000,
		S_XWAIT = 7'b0010000,
		S_MAC   = 7'b0100000,
		S_OUT   = 7'b1000000
	} st_t;

	// which product list the shared multiplier is running
	typedef enum logic [2:0] {
		PH_CROSS = 3'b001,
		PH_STEP  = 3'b010,
		PH_TRANS = 3'b100
	} ph_t;

	st_t   st_q;
	ph_t   ph_q;
	word_t eye_q [3];
	word_t foc_q [3];
	axis_t bas_q [9];
	word_t t_q   [3];
	logic  step_q;
	logic  iss_q;
	logic [1:0] grp_q, sub_q;
	acc_t  acc_q;

	// normalizer hookup
	logic  n_start, n_done;
	diff_t n_d0, n_d1, n_d2;
	axis_t n_o0, n_o1, n_o2;

	// multiplier hookup
	word_t m_a, m_b;
	mtag_t m_tag, p_tag;
	logic signed [PROD_W-1:0] p_s1;

	word_t in_a [3];
	word_t in_b [3];
	logic  in_xfer;
	logic  sub_last;
	acc_t  s_sum;
	acc_t  s_shr;

	assign in_xfer = in_valid && !in_stall;
	assign in_a[0] = a_x;
	assign in_a[1] = a_y;
	assign in_a[2] = a_z;
	assign in_b[0] = b_x;
	assign in_b[1] = b_y;
	assign in_b[2] = b_z;

	// view axis from eye minus focus, then right axis from up cross view axis
	always_comb begin
		n_start = (st_q == S_ZGO) || (st_q == S_XGO);
		if (st_q == S_XGO) begin
			n_d0 = DIFF_W'(bas_q[8]);
			n_d1 = '0;
			n_d2 = -DIFF_W'(bas_q[6]);
		end else begin
			n_d0 = DIFF_W'(eye_q[0]) - DIFF_W'(foc_q[0]);
			n_d1 = DIFF_W'(eye_q[1]) - DIFF_W'(foc_q[1]);
			n_d2 = DIFF_W'(eye_q[2]) - DIFF_W'(foc_q[2]);
		end
	end

	lavm_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (n_start),
		.d0     (n_d0),
		.d1     (n_d1),
		.d2     (n_d2),
		.done   (n_done),
		.o0     (n_o0),
		.o1     (n_o1),
		.o2     (n_o2)
	);

	// operand select for the product lists
	always_comb begin
		m_a      = '0;
		m_b      = '0;
		sub_last = 1'b1;
		unique case (ph_q)
			PH_CROSS: begin
				// up axis = view cross right, two products per component
				sub_last = (sub_q == 2'd1);
				unique case ({grp_q, sub_q[0]})
					3'b000:  begin m_a = WORD_BITS'(bas_q[7]); m_b = WORD_BITS'(bas_q[2]); end
					3'b001:  begin m_a = WORD_BITS'(bas_q[8]); m_b = WORD_BITS'(bas_q[1]); end
					3'b010:  begin m_a = WORD_BITS'(bas_q[8]); m_b = WORD_BITS'(bas_q[0]); end
					3'b011:  begin m_a = WORD_BITS'(bas_q[6]); m_b = WORD_BITS'(bas_q[2]); end
					3'b100:  begin m_a = WORD_BITS'(bas_q[6]); m_b = WORD_BITS'(bas_q[1]); end
					default: begin m_a = WORD_BITS'(bas_q[7]); m_b = WORD_BITS'(bas_q[0]); end
				endcase
			end
			PH_STEP: begin
				sub_last = 1'b1;
				m_a = WORD_BITS'(bas_q[4'd6 + 4'(grp_q)]);
				m_b = WORD_BITS'(STEP_005);
			end
			default: begin
				// translation: axis row times eye
				sub_last = (sub_q == 2'd2);
				m_a = WORD_BITS'(bas_q[4'(grp_q) * 4'd3 + 4'(sub_q)]);
				m_b = eye_q[sub_q];
			end
		endcase
		m_tag.vld  = iss_q && (st_q == S_MAC);
		m_tag.neg  = (ph_q == PH_CROSS) && sub_q[0];
		m_tag.last = sub_last;
		m_tag.grp  = grp_q;
	end

	lavm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (m_a),
		.b      (m_b),
		.tag    (m_tag),
		.p_s1   (p_s1),
		.tag_s1 (p_tag)
	);

	assign s_sum = acc_q + (p_tag.neg ? -acc_t'(p_s1) : acc_t'(p_s1));
	assign s_shr = s_sum >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			ph_q   <= PH_TRANS;
			step_q <= 1'b0;
			iss_q  <= 1'b0;
			grp_q  <= '0;
			sub_q  <= '0;
			acc_q  <= '0;
			eye_q[0] <= '0;
			eye_q[1] <= '0;
			eye_q[2] <= sat_word(5 * ONE);
			for (int i = 0; i < 3; i++) foc_q[i] <= '0;
			for (int i = 0; i < 9; i++) bas_q[i] <= (i % 4 == 0) ? AX_W'(ONE) : '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_xfer) begin
						step_q <= (op_t'(op) == OP_LOOK) && !orbit;
						unique case (op_t'(op))
							OP_LOOK: begin
								for (int i = 0; i < 3; i++) begin
									eye_q[i] <= in_a[i];
									foc_q[i] <= in_b[i];
								end
								st_q <= S_ZGO;
							end
							OP_LOOK_AT: begin
								for (int i = 0; i < 3; i++) foc_q[i] <= in_b[i];
								st_q <= S_ZGO;
							end
							OP_MOVE: begin
								for (int i = 0; i < 3; i++) begin
									eye_q[i] <= sat_word(acc_t'(eye_q[i]) + acc_t'(in_a[i]));
									foc_q[i] <= sat_word(acc_t'(foc_q[i]) + acc_t'(in_a[i]));
								end
								st_q  <= S_MAC;
								ph_q  <= PH_TRANS;
								iss_q <= 1'b1;
								grp_q <= '0;
								sub_q <= '0;
								acc_q <= '0;
							end
							default: begin
								st_q  <= S_MAC;
								ph_q  <= PH_TRANS;
								iss_q <= 1'b1;
								grp_q <= '0;
								sub_q <= '0;
								acc_q <= '0;
							end
						endcase
					end
				end
				S_ZGO: begin
					st_q <= S_ZWAIT;
				end
				S_ZWAIT: begin
					if (n_done) begin
						bas_q[6] <= n_o0;
						bas_q[7] <= n_o1;
						bas_q[8] <= n_o2;
						st_q     <= S_XGO;
					end
				end
				S_XGO: begin
					st_q <= S_XWAIT;
				end
				S_XWAIT: begin
					if (n_done) begin
						bas_q[0] <= n_o0;
						bas_q[1] <= n_o1;
						bas_q[2] <= n_o2;
						st_q     <= S_MAC;
						ph_q     <= PH_CROSS;
						iss_q    <= 1'b1;
						grp_q    <= '0;
						sub_q    <= '0;
						acc_q    <= '0;
					end
				end
				S_MAC: begin
					// issue side
					if (iss_q) begin
						if (sub_last) begin
							sub_q <= '0;
							if (grp_q == 2'd2) begin
								iss_q <= 1'b0;
							end else begin
								grp_q <= grp_q + 2'd1;
							end
						end else begin
							sub_q <= sub_q + 2'd1;
						end
					end
					// accumulate side, one product behind
					if (p_tag.vld) begin
						if (p_tag.last) begin
							acc_q <= '0;
							unique case (ph_q)
								PH_CROSS: bas_q[4'd3 + 4'(p_tag.grp)] <= clamp_axis(s_shr);
								PH_STEP: begin
									foc_q[p_tag.grp] <= eye_q[p_tag.grp];
									eye_q[p_tag.grp] <= sat_word(acc_t'(eye_q[p_tag.grp]) + s_shr);
								end
								default: begin
								end
							endcase
							if (p_tag.grp == 2'd2) begin
								unique case (ph_q)
									PH_CROSS: begin
										ph_q  <= step_q ? PH_STEP : PH_TRANS;
										iss_q <= 1'b1;
										grp_q <= '0;
										sub_q <= '0;
									end
									PH_STEP: begin
										ph_q  <= PH_TRANS;
										iss_q <= 1'b1;
										grp_q <= '0;
										sub_q <= '0;
									end
									default: begin
										st_q <= S_OUT;
									end
								endcase
							end
						end else begin
							acc_q <= s_sum;
						end
					end
				end
				default: begin
					if (!out_stall) begin
						st_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// translation results, payload only
	always_ff @(posedge clk) begin
		if (st_q == S_MAC && p_tag.vld && p_tag.last && ph_q == PH_TRANS) begin
			t_q[p_tag.grp] <= sat_word(-s_shr);
		end
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);

	assign r00 = bas_q[0];
	assign r01 = bas_q[1];
	assign r02 = bas_q[2];
	assign r10 = bas_q[3];
	assign r11 = bas_q[4];
	assign r12 = bas_q[5];
	assign r20 = bas_q[6];
	assign r21 = bas_q[7];
	assign r22 = bas_q[8];
	assign t_x = t_q[0];
	assign t_y = t_q[1];
	assign t_z = t_q[2];

	// a result is never shown while a new item could be taken
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("result shown while input side is open");

	// an input transfer always closes the input side on the next cycle
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input side still open after a transfer");

	// the multiplier only produces tagged products while the product lists run
	a_mac_tags: assert property (@(posedge clk) disable iff (!arst_n)
		p_tag.vld |-> $past(st_q == S_MAC))
		else $error("product tag outside the multiply phase");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for the look-at camera block, with its own fixed-point camera
// model in a small scoreboard class; depends on lavm_pkg and look_at_view_matrix
module tb_top;
	import lavm_pkg::*;

	// one expected view matrix: rotation rows then translation
	typedef struct {
		logic signed [17:0] rot [9];
		logic signed [31:0] trans [3];
	} view_t;

	class camera_scoreboard;
		longint eye [3];
		longint focus [3];
		longint basis [9];
		view_t  pending [$];
		int     mismatches;

		function new();
			eye = '{0, 0, 5 * 65536};
			focus = '{0, 0, 0};
			foreach (basis[i]) basis[i] = (i % 4 == 0) ? 65536 : 0;
			mismatches = 0;
		endfunction

		function longint clip(longint x, longint lo, longint hi);
			return x < lo ? lo : (x > hi ? hi : x);
		endfunction

		function longint sat32(longint x);
			return clip(x, -64'sd2147483648, 64'sd2147483647);
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] x);
			bit [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x = x - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// unit vector; zero in gives zero out
		function void unit_vec(input longint d [3], output longint o [3]);
			longint m, a, v [3];
			bit [63:0] sum, len;
			int sr, sl;
			m = 0;
			sum = 0;
			sr = 0;
			sl = 0;
			for (int i = 0; i < 3; i++) begin
				a = d[i] < 0 ? -d[i] : d[i];
				if (a > m) m = a;
			end
			o = '{0, 0, 0};
			if (m == 0) return;
			while ((m >>> sr) >= (64'sd1 << 30)) sr++;
			while ((m <<< sl) < (64'sd1 << 29)) sl++;
			for (int i = 0; i < 3; i++) begin
				v[i] = sr != 0 ? (d[i] >>> sr) : (d[i] <<< sl);
				sum += 64'(v[i] * v[i]);
			end
			len = int_sqrt(sum);
			if (len == 0) return;
			for (int i = 0; i < 3; i++)
				o[i] = clip((v[i] * 65536) / longint'(len), -65536, 65536);
		endfunction

		function longint cross_part(longint a, longint b, longint c, longint d);
			return clip((a * b - c * d) >>> FRAC_BITS, -65536, 65536);
		endfunction

		function void rebuild_axes();
			longint d [3], zv [3], xr [3], xv [3];
			for (int i = 0; i < 3; i++) d[i] = eye[i] - focus[i];
			unit_vec(d, zv);
			xr = '{zv[2], 0, -zv[0]};
			unit_vec(xr, xv);
			for (int i = 0; i < 3; i++) begin
				basis[i] = xv[i];
				basis[6 + i] = zv[i];
			end
			basis[3] = cross_part(zv[1], xv[2], zv[2], xv[1]);
			basis[4] = cross_part(zv[2], xv[0], zv[0], xv[2]);
			basis[5] = cross_part(zv[0], xv[1], zv[1], xv[0]);
		endfunction

		// -(axis . eye), split to keep the products small, floored, saturated
		function longint neg_dot(int row);
			longint hs, ls, hi;
			hs = 0;
			ls = 0;
			for (int i = 0; i < 3; i++) begin
				hi = eye[i] >>> FRAC_BITS;
				hs += basis[3 * row + i] * hi;
				ls += basis[3 * row + i] * (eye[i] - hi * 65536);
			end
			return sat32(-(hs + (ls >>> FRAC_BITS)));
		endfunction

		// an accepted input transfer: advance the camera and queue the view
		function void note_input(op_t op, bit orb, longint a [3], longint b [3]);
			view_t v;
			case (op)
				OP_LOOK: begin
					eye = a;
					focus = b;
					rebuild_axes();
					if (!orb) begin
						for (int i = 0; i < 3; i++) begin
							focus[i] = eye[i];
							eye[i] = sat32(eye[i] + ((basis[6 + i] * 3277) >>> FRAC_BITS));
						end
					end
				end
				OP_LOOK_AT: begin
					focus = b;
					rebuild_axes();
				end
				OP_MOVE: begin
					for (int i = 0; i < 3; i++) begin
						eye[i] = sat32(eye[i] + a[i]);
						focus[i] = sat32(focus[i] + a[i]);
					end
				end
				default: ;
			endcase
			foreach (v.rot[i]) v.rot[i] = 18'(clip(basis[i], -131072, 131071));
			foreach (v.trans[i]) v.trans[i] = 32'(neg_dot(i));
			pending.push_back(v);
		endfunction

		function void check_result(view_t got);
			view_t want;
			bit bad;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: result transfer with nothing expected");
				return;
			end
			want = pending.pop_front();
			bad = 0;
			foreach (want.rot[i]) if (want.rot[i] !== got.rot[i]) bad = 1;
			foreach (want.trans[i]) if (want.trans[i] !== got.trans[i]) bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: view mismatch at %0t", $realtime);
					$display("  rot exp %p", want.rot);
					$display("  rot got %p", got.rot);
					$display("  t   exp %p got %p", want.trans, got.trans);
				end
			end
		endfunction
	endclass

	logic               clk, arst_n;
	logic               in_valid, in_stall, out_valid, out_stall;
	logic [1:0]         op;
	logic               orbit;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
	logic signed [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [31:0] t_x, t_y, t_z;

	camera_scoreboard sb;
	int sender_idle, recv_idle;

	look_at_view_matrix DUT (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// receiver: random stall, check every result transfer
	always @(posedge clk) begin
		view_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.rot = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			got.trans = '{t_x, t_y, t_z};
			sb.check_result(got);
		end
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// one input transfer; valid stays high into the next item when no gap follows
	task automatic send_item(op_t o, bit orb, longint a [3], longint b [3]);
		while ($urandom_range(0, 99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		orbit <= orb;
		a_x <= 32'(a[0]);
		a_y <= 32'(a[1]);
		a_z <= 32'(a[2]);
		b_x <= 32'(b[0]);
		b_y <= 32'(b[1]);
		b_z <= 32'(b[2]);
		do @(posedge clk); while (in_stall);
		sb.note_input(o, orb, a, b);
	endtask

	// mostly scene-sized coordinates, sometimes tiny, sometimes any 32-bit value
	function automatic longint rand_coord();
		case ($urandom_range(0, 9))
			0: return longint'($signed($urandom()));
			1: return longint'($urandom_range(0, 131072)) - 65536;
			default: return longint'($urandom_range(0, 26214400)) - 13107200;
		endcase
	endfunction

	task automatic random_item();
		longint a [3], b [3];
		int pick;
		op_t o;
		foreach (a[i]) a[i] = rand_coord();
		foreach (b[i]) b[i] = rand_coord();
		pick = $urandom_range(0, 99);
		o = pick < 40 ? OP_LOOK : pick < 70 ? OP_LOOK_AT : pick < 95 ? OP_MOVE : OP_NONE;
		// move offsets kept small most of the time so the camera stays in range
		if (o == OP_MOVE && $urandom_range(0, 9) != 0)
			foreach (a[i]) a[i] = longint'($urandom_range(0, 1310720)) - 655360;
		// degenerate targets: same as eye, or straight above or below it
		case ($urandom_range(0, 19))
			0: begin
				if (o == OP_LOOK) b = a;
				else b = sb.eye;
			end
			1: begin
				if (o == OP_LOOK) b = a;
				else b = sb.eye;
				b[1] = rand_coord();
			end
			default: ;
		endcase
		send_item(o, 1'($urandom_range(0, 1)), a, b);
	endtask

	localparam longint PMAX = 64'sd2147483647;
	localparam longint NMAX = -64'sd2147483648;

	initial begin
		sb = new();
		sender_idle = 32;
		recv_idle = 85;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_NONE;
		orbit = 1'b0;
		{a_x, a_y, a_z, b_x, b_y, b_z} = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset view, each op, zero and up-parallel view axes, extremes
		send_item(OP_NONE, 0, '{0, 0, 0}, '{0, 0, 0});
		send_item(OP_LOOK, 1, '{0, 0, 5 * 65536}, '{0, 0, 0});
		send_item(OP_LOOK, 0, '{65536, 2 * 65536, 3 * 65536}, '{0, 0, 0});
		send_item(OP_LOOK, 1, '{7 * 65536, 0, 0}, '{7 * 65536, 0, 0});
		send_item(OP_LOOK, 0, '{0, 3 * 65536, 0}, '{0, -4 * 65536, 0});
		send_item(OP_LOOK, 1, '{0, -65536, 0}, '{0, 65536, 0});
		send_item(OP_LOOK_AT, 1, '{PMAX, PMAX, PMAX}, '{65536, -65536, 65536});
		send_item(OP_MOVE, 0, '{PMAX, PMAX, PMAX}, '{0, 0, 0});
		send_item(OP_MOVE, 1, '{PMAX, NMAX, 0}, '{0, 0, 0});
		send_item(OP_LOOK_AT, 0, '{0, 0, 0}, '{NMAX, NMAX, NMAX});
		send_item(OP_LOOK, 1, '{PMAX, PMAX, PMAX}, '{NMAX, NMAX, NMAX});
		send_item(OP_LOOK, 0, '{NMAX, NMAX, NMAX}, '{PMAX, PMAX, PMAX});
		send_item(OP_LOOK, 1, '{PMAX, 0, NMAX}, '{NMAX, 0, PMAX});
		send_item(OP_MOVE, 0, '{NMAX, NMAX, NMAX}, '{PMAX, PMAX, PMAX});
		send_item(OP_NONE, 1, '{PMAX, PMAX, PMAX}, '{NMAX, NMAX, NMAX});
		send_item(OP_LOOK, 0, '{1, 1, 1}, '{0, 0, 0});
		send_item(OP_LOOK, 1, '{-1, 0, 0}, '{0, 0, -1});
		send_item(OP_LOOK_AT, 1, '{0, 0, 0}, '{0, 1, 0});
		send_item(OP_MOVE, 0, '{-1, -1, -1}, '{0, 0, 0});
		send_item(OP_LOOK, 0, '{0, 0, 0}, '{0, 0, 0});

		// random, three idle profiles
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle = phase == 0 ? 32 : phase == 1 ? 85 : 0;
			recv_idle = phase == 0 ? 85 : phase == 1 ? 32 : 0;
			repeat (450) random_item();
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.mismatches == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
